FILE: design/lcd4w_pkg.sv
// ----------------------------------------------------------------------------
// lcd4w_pkg
// Types, constants and helper function of the 4-bit character LCD writer.
// ----------------------------------------------------------------------------
package lcd4w_pkg;

   // Request kinds.
   localparam logic [1:0] REQ_COMMAND = 2'd0;
   localparam logic [1:0] REQ_DATA    = 2'd1;
   localparam logic [1:0] REQ_CURSOR  = 2'd2;
   localparam logic [1:0] REQ_INIT    = 2'd3;

   // Control register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_WAIT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_WAIT   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_WAIT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POWERUP     = 3'd4;

   localparam int unsigned HOLD_WIDTH = 16;

   // Register reset values.
   localparam logic [HOLD_WIDTH-1:0] PULSE_WIDTH_RESET = 16'd1;
   localparam logic [HOLD_WIDTH-1:0] SHORT_WAIT_RESET  = 16'd50;
   localparam logic [HOLD_WIDTH-1:0] LONG_WAIT_RESET   = 16'd2000;
   localparam logic [HOLD_WIDTH-1:0] DATA_WAIT_RESET   = 16'd50;
   localparam logic [HOLD_WIDTH-1:0] POWERUP_RESET     = 16'd50000;

   // Fixed gaps of the init sequence.
   localparam logic [HOLD_WIDTH-1:0] INIT_FIRST_GAP_US = 16'd5000;
   localparam logic [HOLD_WIDTH-1:0] INIT_GAP_US       = 16'd150;

   // LCD command bytes.
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [3:0] ROW1_BASE      = 4'hC;
   localparam logic [3:0] ROW0_BASE      = 4'h8;
   localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;

   // Step counts.
   localparam int unsigned STEP_WIDTH     = 6;
   localparam logic [STEP_WIDTH-1:0] BYTE_LAST_STEP = 6'd5;
   localparam logic [STEP_WIDTH-1:0] INIT_LAST_STEP = 6'd37;

   typedef enum logic [2:0] {
      HOLD_PULSE,
      HOLD_WAIT,
      HOLD_POWERUP,
      HOLD_LONG,
      HOLD_FIRST_GAP,
      HOLD_GAP
   } hold_sel_type;

   // One pin state before the hold time and nibble source are resolved.
   typedef struct packed {
      logic         en;
      logic         keep;
      logic [3:0]   nibble;
      hold_sel_type hold_sel;
   } pin_step_type;

   // Pin state number slot (0 to 5) of a byte write.
   function automatic pin_step_type byte_slot(input logic [2:0] slot,
                                              input logic [7:0] value);
      pin_step_type s;
      s.en       = 1'b0;
      s.keep     = 1'b0;
      s.nibble   = value[7:4];
      s.hold_sel = HOLD_PULSE;
      unique case (slot)
         3'd0: begin
            s.keep = 1'b1;
         end
         3'd1: begin
            s.en = 1'b1;
         end
         3'd2: begin
            s.en = 1'b0;
         end
         3'd3: begin
            s.en     = 1'b1;
            s.nibble = value[3:0];
         end
         3'd4: begin
            s.nibble = value[3:0];
         end
         default: begin
            s.nibble   = value[3:0];
            s.hold_sel = HOLD_WAIT;
         end
      endcase
      return s;
   endfunction

endpackage

FILE: design/lcd4w_if.sv
// ----------------------------------------------------------------------------
// lcd4w_if
// Valid/ready channels of the LCD writer: requests in, pin states out.
// ----------------------------------------------------------------------------
interface lcd4w_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] byte_value;
   logic       cursor_row;
   logic [3:0] cursor_col;

   modport source (output valid, req_type, byte_value, cursor_row, cursor_col,
                   input ready);
   modport sink   (input valid, req_type, byte_value, cursor_row, cursor_col,
                   output ready);
endinterface

interface lcd4w_rsp_if;
   logic        valid;
   logic        ready;
   logic        rs_level;
   logic        rw_level;
   logic        enable_level;
   logic [3:0]  data_nibble;
   logic [15:0] hold_us;
   logic        last;

   modport source (output valid, rs_level, rw_level, enable_level, data_nibble,
                   hold_us, last, input ready);
   modport sink   (input valid, rs_level, rw_level, enable_level, data_nibble,
                   hold_us, last, output ready);
endinterface

FILE: design/char_lcd_4bit_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_writer
// Turns LCD requests into timed pin states for a 4-bit HD44780-type bus.
// ----------------------------------------------------------------------------
// A command, data or cursor request yields 6 pin states and the init request
// yields 38, one per clock cycle from a step counter into the output register
// whenever the result side takes every state. The next request is accepted in
// the same cycle the current request's last state is loaded into the output
// register, so consecutive requests leave no gap. Control registers are
// written through the csr_ port and must only be changed while no request is
// in progress.
module char_lcd_4bit_writer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [lcd4w_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lcd4w_pkg::HOLD_WIDTH-1:0]        csr_wdata,
   lcd4w_req_if.sink                               req_chan,
   lcd4w_rsp_if.source                             rsp_chan
);

   // Control registers.
   logic [lcd4w_pkg::HOLD_WIDTH-1:0] pulse_width_ff;
   logic [lcd4w_pkg::HOLD_WIDTH-1:0] short_wait_ff;
   logic [lcd4w_pkg::HOLD_WIDTH-1:0] long_wait_ff;
   logic [lcd4w_pkg::HOLD_WIDTH-1:0] data_wait_ff;
   logic [lcd4w_pkg::HOLD_WIDTH-1:0] powerup_ff;

   // Sequencer state.
   logic                              busy_ff,   busy_in;
   logic                              init_ff,   init_in;
   logic                              rs_ff,     rs_in;
   logic [7:0]                        byte_ff,   byte_in;
   logic [lcd4w_pkg::STEP_WIDTH-1:0]  step_ff,   step_in;
   logic [3:0]                        pin_nibble_ff, pin_nibble_in;

   // Output register.
   logic                              out_valid_ff, out_valid_in;
   logic                              out_rs_ff;
   logic                              out_en_ff;
   logic [3:0]                        out_nibble_ff;
   logic [lcd4w_pkg::HOLD_WIDTH-1:0]  out_hold_ff;
   logic                              out_last_ff;

   logic                              advance;
   logic                              is_last;
   logic                              req_accept;
   logic [7:0]                        cur_byte;
   logic [2:0]                        cur_slot;
   lcd4w_pkg::pin_step_type           cur_step;
   logic [3:0]                        gen_nibble;
   logic [lcd4w_pkg::HOLD_WIDTH-1:0]  gen_hold;
   logic [lcd4w_pkg::STEP_WIDTH-1:0]  step_rel;
   logic [7:0]                        eff_byte;

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= lcd4w_pkg::PULSE_WIDTH_RESET;
         short_wait_ff  <= lcd4w_pkg::SHORT_WAIT_RESET;
         long_wait_ff   <= lcd4w_pkg::LONG_WAIT_RESET;
         data_wait_ff   <= lcd4w_pkg::DATA_WAIT_RESET;
         powerup_ff     <= lcd4w_pkg::POWERUP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lcd4w_pkg::CSR_PULSE_WIDTH: pulse_width_ff <= csr_wdata;
            lcd4w_pkg::CSR_SHORT_WAIT:  short_wait_ff  <= csr_wdata;
            lcd4w_pkg::CSR_LONG_WAIT:   long_wait_ff   <= csr_wdata;
            lcd4w_pkg::CSR_DATA_WAIT:   data_wait_ff   <= csr_wdata;
            lcd4w_pkg::CSR_POWERUP:     powerup_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   assign advance  = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign is_last  = init_ff ? (step_ff == lcd4w_pkg::INIT_LAST_STEP)
                             : (step_ff == lcd4w_pkg::BYTE_LAST_STEP);

   assign req_chan.ready = !busy_ff || (advance && is_last);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // A cursor move is sent as a set-address command.
   always_comb begin
      if (req_chan.req_type == lcd4w_pkg::REQ_CURSOR) begin
         eff_byte = {(req_chan.cursor_row ? lcd4w_pkg::ROW1_BASE : lcd4w_pkg::ROW0_BASE),
                     req_chan.cursor_col};
      end else begin
         eff_byte = req_chan.byte_value;
      end
   end

   // ------------------------------------------------------------------------
   // Step decode
   // ------------------------------------------------------------------------
   always_comb begin
      cur_byte = byte_ff;
      cur_slot = step_ff[2:0];
      step_rel = step_ff;
      cur_step = lcd4w_pkg::byte_slot(cur_slot, cur_byte);
      if (init_ff) begin
         priority if (step_ff == 6'd0) begin
            cur_step.en       = 1'b0;
            cur_step.keep     = 1'b1;
            cur_step.nibble   = 4'h0;
            cur_step.hold_sel = lcd4w_pkg::HOLD_POWERUP;
         end else if (step_ff <= 6'd12) begin
            // Four wake-up nibbles, each as enable high, enable low, gap.
            cur_step.nibble = (step_ff <= 6'd9) ? lcd4w_pkg::WAKE_NIBBLE
                                                : lcd4w_pkg::FOUR_BIT_NIBBLE;
            cur_step.keep   = 1'b0;
            if (step_ff == 6'd1 || step_ff == 6'd4 || step_ff == 6'd7 ||
                step_ff == 6'd10) begin
               cur_step.en       = 1'b1;
               cur_step.hold_sel = lcd4w_pkg::HOLD_PULSE;
            end else if (step_ff == 6'd2 || step_ff == 6'd5 || step_ff == 6'd8 ||
                         step_ff == 6'd11) begin
               cur_step.en       = 1'b0;
               cur_step.hold_sel = lcd4w_pkg::HOLD_PULSE;
            end else begin
               cur_step.en       = 1'b0;
               cur_step.hold_sel = (step_ff == 6'd3) ? lcd4w_pkg::HOLD_FIRST_GAP
                                                     : lcd4w_pkg::HOLD_GAP;
            end
         end else if (step_ff <= 6'd18) begin
            step_rel = step_ff - 6'd13;
            cur_byte = lcd4w_pkg::CMD_FUNC_SET;
            cur_slot = step_rel[2:0];
            cur_step = lcd4w_pkg::byte_slot(cur_slot, cur_byte);
         end else if (step_ff <= 6'd24) begin
            step_rel = step_ff - 6'd19;
            cur_byte = lcd4w_pkg::CMD_DISPLAY_ON;
            cur_slot = step_rel[2:0];
            cur_step = lcd4w_pkg::byte_slot(cur_slot, cur_byte);
         end else if (step_ff <= 6'd30) begin
            step_rel = step_ff - 6'd25;
            cur_byte = lcd4w_pkg::CMD_CLEAR;
            cur_slot = step_rel[2:0];
            cur_step = lcd4w_pkg::byte_slot(cur_slot, cur_byte);
         end else if (step_ff == 6'd31) begin
            // Extra settle time after the clear command.
            cur_step.en       = 1'b0;
            cur_step.keep     = 1'b1;
            cur_step.nibble   = 4'h0;
            cur_step.hold_sel = lcd4w_pkg::HOLD_LONG;
         end else begin
            step_rel = step_ff - 6'd32;
            cur_byte = lcd4w_pkg::CMD_ENTRY_MODE;
            cur_slot = step_rel[2:0];
            cur_step = lcd4w_pkg::byte_slot(cur_slot, cur_byte);
         end
      end
   end

   assign gen_nibble = cur_step.keep ? pin_nibble_ff : cur_step.nibble;

   always_comb begin
      unique case (cur_step.hold_sel)
         lcd4w_pkg::HOLD_PULSE:     gen_hold = pulse_width_ff;
         lcd4w_pkg::HOLD_WAIT: begin
            if (rs_ff) begin
               gen_hold = data_wait_ff;
            end else if (cur_byte == lcd4w_pkg::CMD_CLEAR ||
                         cur_byte == lcd4w_pkg::CMD_HOME) begin
               gen_hold = long_wait_ff;
            end else begin
               gen_hold = short_wait_ff;
            end
         end
         lcd4w_pkg::HOLD_POWERUP:   gen_hold = powerup_ff;
         lcd4w_pkg::HOLD_LONG:      gen_hold = long_wait_ff;
         lcd4w_pkg::HOLD_FIRST_GAP: gen_hold = lcd4w_pkg::INIT_FIRST_GAP_US;
         lcd4w_pkg::HOLD_GAP:       gen_hold = lcd4w_pkg::INIT_GAP_US;
         default:                   gen_hold = pulse_width_ff;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      busy_in       = busy_ff;
      init_in       = init_ff;
      rs_in         = rs_ff;
      byte_in       = byte_ff;
      step_in       = step_ff;
      pin_nibble_in = pin_nibble_ff;
      if (advance) begin
         pin_nibble_in = gen_nibble;
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 6'd1;
         end
      end
      if (req_accept) begin
         busy_in = 1'b1;
         init_in = (req_chan.req_type == lcd4w_pkg::REQ_INIT);
         rs_in   = (req_chan.req_type == lcd4w_pkg::REQ_DATA);
         byte_in = eff_byte;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         init_ff       <= 1'b0;
         step_ff       <= '0;
         pin_nibble_ff <= 4'h0;
      end else begin
         busy_ff       <= busy_in;
         init_ff       <= init_in;
         step_ff       <= step_in;
         pin_nibble_ff <= pin_nibble_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff   <= rs_in;
      byte_ff <= byte_in;
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rs_ff     <= rs_ff;
         out_en_ff     <= cur_step.en;
         out_nibble_ff <= gen_nibble;
         out_hold_ff   <= gen_hold;
         out_last_ff   <= is_last;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.rs_level     = out_rs_ff;
   assign rsp_chan.rw_level     = 1'b0;
   assign rsp_chan.enable_level = out_en_ff;
   assign rsp_chan.data_nibble  = out_nibble_ff;
   assign rsp_chan.hold_us      = out_hold_ff;
   assign rsp_chan.last         = out_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A request may only be taken while busy when the last state goes out.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && busy_ff) |-> (advance && is_last))
      else $error("request accepted in the middle of a sequence");

   // Every sequence ends with the enable strobe low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last) |-> !rsp_chan.enable_level)
      else $error("last pin state has enable high");

   // A byte request never runs past its sixth state.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !init_ff) |-> (step_ff <= lcd4w_pkg::BYTE_LAST_STEP))
      else $error("byte request step out of range");

   // An enable pulse is always followed by enable low on the next state.
   assert property (@(posedge clock) disable iff (reset)
      (advance && cur_step.en) |=> (busy_ff && !cur_step.en))
      else $error("two enable-high states in a row");

endmodule

FILE: dv/char_lcd_4bit_writer_test.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_writer_test
// Drives command, data, cursor and init requests into the LCD writer under
// several register settings and random flow control, predicts every pin
// state the writer should produce, and compares the pin states field by field.
// ----------------------------------------------------------------------------
module char_lcd_4bit_writer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_W      = lcd4w_pkg::HOLD_WIDTH;
   localparam int unsigned INDEX_W     = lcd4w_pkg::CSR_INDEX_WIDTH;

   typedef struct packed {
      logic              rs;
      logic              rw;
      logic              en;
      logic [3:0]        nibble;
      logic [HOLD_W-1:0] hold;
      logic              last;
   } pin_state_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [INDEX_W-1:0] csr_index;
   logic [HOLD_W-1:0]  csr_wdata;

   lcd4w_req_if req_chan ();
   lcd4w_rsp_if rsp_chan ();

   char_lcd_4bit_writer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Predicted LCD state and register copies.
   logic [3:0]        pins_now;
   logic [HOLD_W-1:0] pulse_us;
   logic [HOLD_W-1:0] short_wait_us;
   logic [HOLD_W-1:0] long_wait_us;
   logic [HOLD_W-1:0] data_wait_us;
   logic [HOLD_W-1:0] powerup_us;

   pin_state_type expected_pins[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned sender_max_gap = 4;
   logic [7:0]  receiver_pattern = 8'hFF;
   logic [2:0]  pattern_pos = 3'd0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("char_lcd_4bit_writer_test: errors");
         $finish;
      end
   end

   // The receiver stalls on a rotating pattern of eight ready bits.
   always @(posedge clock) begin
      rsp_chan.ready <= receiver_pattern[pattern_pos];
      pattern_pos    <= pattern_pos + 3'd1;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void push_pin_state(input logic rs, input logic en,
                                          input logic [3:0] nib,
                                          input logic [HOLD_W-1:0] hold);
      pin_state_type s;
      pins_now = nib;
      s.rs     = rs;
      s.rw     = 1'b0;
      s.en     = en;
      s.nibble = nib;
      s.hold   = hold;
      s.last   = 1'b0;
      expected_pins.push_back(s);
   endfunction

   function automatic void push_strobe(input logic rs, input logic [3:0] nib);
      push_pin_state(rs, 1'b1, nib, pulse_us);
      push_pin_state(rs, 1'b0, nib, pulse_us);
   endfunction

   function automatic void push_byte_write(input logic rs, input logic [7:0] value);
      logic [HOLD_W-1:0] settle;
      if (rs)
         settle = data_wait_us;
      else if (value == lcd4w_pkg::CMD_CLEAR || value == lcd4w_pkg::CMD_HOME)
         settle = long_wait_us;
      else
         settle = short_wait_us;
      push_pin_state(rs, 1'b0, pins_now, pulse_us);
      push_strobe(rs, value[7:4]);
      push_strobe(rs, value[3:0]);
      push_pin_state(rs, 1'b0, pins_now, settle);
   endfunction

   function automatic void predict_pin_states(input logic [1:0] kind,
                                              input logic [7:0] value,
                                              input logic row,
                                              input logic [3:0] col);
      unique case (kind)
         lcd4w_pkg::REQ_COMMAND: push_byte_write(1'b0, value);
         lcd4w_pkg::REQ_DATA:    push_byte_write(1'b1, value);
         lcd4w_pkg::REQ_CURSOR:
            push_byte_write(1'b0, {row ? lcd4w_pkg::ROW1_BASE : lcd4w_pkg::ROW0_BASE,
                                   col});
         default: begin
            push_pin_state(1'b0, 1'b0, pins_now, powerup_us);
            push_strobe(1'b0, lcd4w_pkg::WAKE_NIBBLE);
            push_pin_state(1'b0, 1'b0, pins_now, lcd4w_pkg::INIT_FIRST_GAP_US);
            push_strobe(1'b0, lcd4w_pkg::WAKE_NIBBLE);
            push_pin_state(1'b0, 1'b0, pins_now, lcd4w_pkg::INIT_GAP_US);
            push_strobe(1'b0, lcd4w_pkg::WAKE_NIBBLE);
            push_pin_state(1'b0, 1'b0, pins_now, lcd4w_pkg::INIT_GAP_US);
            push_strobe(1'b0, lcd4w_pkg::FOUR_BIT_NIBBLE);
            push_pin_state(1'b0, 1'b0, pins_now, lcd4w_pkg::INIT_GAP_US);
            push_byte_write(1'b0, lcd4w_pkg::CMD_FUNC_SET);
            push_byte_write(1'b0, lcd4w_pkg::CMD_DISPLAY_ON);
            push_byte_write(1'b0, lcd4w_pkg::CMD_CLEAR);
            push_pin_state(1'b0, 1'b0, pins_now, long_wait_us);
            push_byte_write(1'b0, lcd4w_pkg::CMD_ENTRY_MODE);
         end
      endcase
      expected_pins[expected_pins.size() - 1].last = 1'b1;
   endfunction

   function automatic void apply_register(input logic [INDEX_W-1:0] index,
                                          input logic [HOLD_W-1:0] value);
      unique case (index)
         lcd4w_pkg::CSR_PULSE_WIDTH: pulse_us      = value;
         lcd4w_pkg::CSR_SHORT_WAIT:  short_wait_us = value;
         lcd4w_pkg::CSR_LONG_WAIT:   long_wait_us  = value;
         lcd4w_pkg::CSR_DATA_WAIT:   data_wait_us  = value;
         lcd4w_pkg::CSR_POWERUP:     powerup_us    = value;
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------ checker

   function automatic void compare_field(input string name,
                                         input logic [HOLD_W-1:0] want,
                                         input logic [HOLD_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_pin_states
      pin_state_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_pins.size() == 0) begin
            error_count++;
            $display("%0t: pin state expected none got rs=%0h en=%0h nibble=%0h hold=%0h",
                     $time, rsp_chan.rs_level, rsp_chan.enable_level,
                     rsp_chan.data_nibble, rsp_chan.hold_us);
         end else begin
            want = expected_pins.pop_front();
            compare_field("rs_level", HOLD_W'(want.rs), HOLD_W'(rsp_chan.rs_level));
            compare_field("rw_level", HOLD_W'(want.rw), HOLD_W'(rsp_chan.rw_level));
            compare_field("enable_level", HOLD_W'(want.en),
                          HOLD_W'(rsp_chan.enable_level));
            compare_field("data_nibble", HOLD_W'(want.nibble),
                          HOLD_W'(rsp_chan.data_nibble));
            compare_field("hold_us", want.hold, rsp_chan.hold_us);
            compare_field("last", HOLD_W'(want.last), HOLD_W'(rsp_chan.last));
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_request(input logic [1:0] kind, input logic [7:0] value,
                               input logic row, input logic [3:0] col);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.byte_value <= value;
      req_chan.cursor_row <= row;
      req_chan.cursor_col <= col;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      predict_pin_states(kind, value, row, col);
   endtask

   // Stops the sender and waits until every predicted pin state has come out.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_pins.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] index,
                                 input logic [HOLD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(index, value);
      @(posedge clock);
   endtask

   task automatic write_all_registers(input logic [HOLD_W-1:0] pulse,
                                      input logic [HOLD_W-1:0] short_wait,
                                      input logic [HOLD_W-1:0] long_wait,
                                      input logic [HOLD_W-1:0] data_wait,
                                      input logic [HOLD_W-1:0] powerup);
      write_register(lcd4w_pkg::CSR_PULSE_WIDTH, pulse);
      write_register(lcd4w_pkg::CSR_SHORT_WAIT, short_wait);
      write_register(lcd4w_pkg::CSR_LONG_WAIT, long_wait);
      write_register(lcd4w_pkg::CSR_DATA_WAIT, data_wait);
      write_register(lcd4w_pkg::CSR_POWERUP, powerup);
   endtask

   task automatic send_random_request();
      int unsigned pick;
      logic [1:0]  kind;
      logic [7:0]  value;
      pick  = $urandom_range(0, 99);
      value = 8'($urandom_range(0, 255));
      if (pick < 35)
         kind = lcd4w_pkg::REQ_COMMAND;
      else if (pick < 70)
         kind = lcd4w_pkg::REQ_DATA;
      else if (pick < 92)
         kind = lcd4w_pkg::REQ_CURSOR;
      else
         kind = lcd4w_pkg::REQ_INIT;
      // Clear and home take the long wait, so they are made more frequent.
      if (kind == lcd4w_pkg::REQ_COMMAND && $urandom_range(0, 4) == 0)
         value = $urandom_range(0, 1) ? lcd4w_pkg::CMD_CLEAR : lcd4w_pkg::CMD_HOME;
      send_request(kind, value, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_power_up_defaults();
      send_request(lcd4w_pkg::REQ_INIT, 8'hFF, 1'b1, 4'hF);
      send_request(lcd4w_pkg::REQ_COMMAND, lcd4w_pkg::CMD_CLEAR, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_DATA, 8'h41, 1'b1, 4'hA);
      drain_results();
   endtask

   task automatic test_directed_requests();
      send_request(lcd4w_pkg::REQ_COMMAND, 8'h00, 1'b1, 4'hF);
      send_request(lcd4w_pkg::REQ_COMMAND, 8'hFF, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_COMMAND, lcd4w_pkg::CMD_HOME, 1'b0, 4'h5);
      send_request(lcd4w_pkg::REQ_COMMAND, 8'h03, 1'b1, 4'h0);
      send_request(lcd4w_pkg::REQ_COMMAND, lcd4w_pkg::CMD_FUNC_SET, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_DATA, 8'h00, 1'b1, 4'hF);
      send_request(lcd4w_pkg::REQ_DATA, 8'hFF, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_CURSOR, 8'h00, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_CURSOR, 8'hFF, 1'b1, 4'hF);
      send_request(lcd4w_pkg::REQ_CURSOR, 8'h55, 1'b0, 4'hF);
      send_request(lcd4w_pkg::REQ_CURSOR, 8'hAA, 1'b1, 4'h0);
      drain_results();
   endtask

   task automatic test_register_extremes();
      write_all_registers('0, '0, '0, '0, '0);
      send_request(lcd4w_pkg::REQ_COMMAND, lcd4w_pkg::CMD_HOME, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_DATA, 8'h5A, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_CURSOR, 8'h00, 1'b1, 4'h7);
      send_request(lcd4w_pkg::REQ_INIT, 8'h00, 1'b0, 4'h0);
      drain_results();
      write_all_registers('1, '1, '1, '1, '1);
      send_request(lcd4w_pkg::REQ_COMMAND, lcd4w_pkg::CMD_CLEAR, 1'b1, 4'hF);
      send_request(lcd4w_pkg::REQ_COMMAND, 8'h80, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_DATA, 8'hA5, 1'b1, 4'hF);
      send_request(lcd4w_pkg::REQ_INIT, 8'hFF, 1'b1, 4'hF);
      drain_results();
   endtask

   // Writes to indexes past the last register must leave every register alone.
   task automatic test_ignored_register_indexes();
      write_all_registers(16'd3, 16'd40, 16'd1600, 16'd45, 16'd40000);
      for (int i = int'(lcd4w_pkg::CSR_POWERUP) + 1; i < 2 ** INDEX_W; i++)
         write_register(INDEX_W'(i), '1);
      send_request(lcd4w_pkg::REQ_COMMAND, lcd4w_pkg::CMD_CLEAR, 1'b0, 4'h0);
      send_request(lcd4w_pkg::REQ_DATA, 8'h7E, 1'b0, 4'h0);
      drain_results();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         unique case (phase)
            0: write_all_registers(lcd4w_pkg::PULSE_WIDTH_RESET,
                                   lcd4w_pkg::SHORT_WAIT_RESET,
                                   lcd4w_pkg::LONG_WAIT_RESET,
                                   lcd4w_pkg::DATA_WAIT_RESET,
                                   lcd4w_pkg::POWERUP_RESET);
            1: write_all_registers('0, '1, '0, '1, '0);
            2: write_all_registers('1, '0, '1, '0, '1);
            default: write_all_registers(HOLD_W'($urandom_range(0, 65535)),
                                         HOLD_W'($urandom_range(0, 65535)),
                                         HOLD_W'($urandom_range(0, 65535)),
                                         HOLD_W'($urandom_range(0, 65535)),
                                         HOLD_W'($urandom_range(0, 65535)));
         endcase
         // One phase runs at full rate on both sides.
         if (phase == 3) begin
            sender_max_gap   = 0;
            receiver_pattern = 8'hFF;
         end else begin
            sender_max_gap   = $urandom_range(1, 12);
            receiver_pattern = 8'($urandom_range(1, 255));
         end
         for (int n = 0; n < 80; n++) begin
            send_random_request();
            if ($urandom_range(0, 49) == 0)
               drain_results();
         end
         drain_results();
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= lcd4w_pkg::CSR_PULSE_WIDTH;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= lcd4w_pkg::REQ_COMMAND;
      req_chan.byte_value <= '0;
      req_chan.cursor_row <= 1'b0;
      req_chan.cursor_col <= '0;
      pins_now      = '0;
      pulse_us      = lcd4w_pkg::PULSE_WIDTH_RESET;
      short_wait_us = lcd4w_pkg::SHORT_WAIT_RESET;
      long_wait_us  = lcd4w_pkg::LONG_WAIT_RESET;
      data_wait_us  = lcd4w_pkg::DATA_WAIT_RESET;
      powerup_us    = lcd4w_pkg::POWERUP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      receiver_pattern = 8'($urandom_range(1, 255));
      test_power_up_defaults();
      test_directed_requests();
      test_register_extremes();
      test_ignored_register_indexes();
      test_random_traffic();

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("char_lcd_4bit_writer_test: clean");
      else
         $display("char_lcd_4bit_writer_test: errors");
      $finish;
   end

endmodule
